/* src/pdt_pkg.sv */
// pdt_pkg: shared types and codes of the per-process descriptor table
// holds the transfer payload structs, request codes and status codes
// no dependencies
package pdt_pkg;

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // input transfer payload
  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] proc_id;
    logic [7:0] desc_num;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] open_count;
  } out_item_t;

endpackage

/* src/pdt_len_ram.sv */
// pdt_len_ram: per-slot list length store with registered read
// one valid bit per slot so that reset reads every length as zero
// depends on nothing but its parameters
module pdt_len_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int LW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [LW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [LW-1:0] wr_data
);

  logic [LW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [LW-1:0]    q_r;
  logic             q_vld_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r     <= mem[rd_addr];
      q_vld_r <= vld_r[rd_addr];
    end
  end

  // an unwritten slot reads as an empty list
  assign rd_data = q_vld_r ? q_r : '0;

endmodule

/* src/pdt_entry_ram.sv */
// pdt_entry_ram: descriptor entry store, one write and one read port
// synchronous read, contents undefined until written
// depends on nothing but its parameters
module pdt_entry_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] q_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  assign rd_data = q_r;

endmodule

/* src/per_process_descriptor_table.sv */
// per_process_descriptor_table: top level, request sequencer and output register
// uses pdt_pkg, pdt_len_ram and pdt_entry_ram
//
// Keeps a list of open descriptor numbers for each of NUM_PROCS process slots,
// up to LIST_DEPTH entries each, in order of arrival. One request is worked at
// a time; a new request is taken whenever the sequencer is idle, even while the
// previous result still waits in the output register. Invalid slot numbers go
// straight to the result; add and clear read the list length and update it; query
// and remove walk the list through the entry memory's single read port at one
// entry a cycle, and remove then shifts every later entry left to close the gap.
// A stalled output register holds the sequencer in its done state. No clearing
// pass is needed after reset: list lengths read as zero until written.
module per_process_descriptor_table #(
  parameter int NUM_PROCS  = 16,
  parameter int LIST_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pdt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pdt_pkg::out_item_t out_data
);

  import pdt_pkg::*;

  localparam int TOTAL = NUM_PROCS * LIST_DEPTH;
  localparam int SW    = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int LW    = $clog2(LIST_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LEN   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    req_r, req_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [7:0]    desc_r, desc_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          len_rd_en, len_wr_en;
  logic [SW-1:0] len_rd_addr;
  logic [LW-1:0] len_q, len_wr_data;
  logic          ent_rd_en, ent_wr_en;
  logic [AW-1:0] ent_rd_addr, ent_wr_addr;
  logic [7:0]    ent_q, ent_wr_data;

  logic          accept;
  logic          pid_bad;
  logic [SW-1:0] in_slot;
  logic [LW:0]   idx_p1, idx_p2, len_ext;
  logic          out_free;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign pid_bad  = (in_data.proc_id == 5'd0) || (32'(in_data.proc_id) > NUM_PROCS);
  assign in_slot  = SW'(in_data.proc_id - 5'd1);
  assign idx_p1   = {1'b0, idx_r} + (LW + 1)'(1);
  assign idx_p2   = {1'b0, idx_r} + (LW + 1)'(2);
  assign len_ext  = {1'b0, len_r};
  assign out_free = !out_valid_r || !out_stall;

  pdt_len_ram #(
    .DEPTH (NUM_PROCS),
    .AW    (SW),
    .LW    (LW)
  ) u_len (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (len_rd_en),
    .rd_addr (len_rd_addr),
    .rd_data (len_q),
    .wr_en   (len_wr_en),
    .wr_addr (slot_r),
    .wr_data (len_wr_data)
  );

  pdt_entry_ram #(
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_ent (
    .clk     (clk),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_q),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_wr_addr),
    .wr_data (ent_wr_data)
  );

  // request sequencer: read length, scan, shift, write back
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    slot_nxt      = slot_r;
    desc_nxt      = desc_r;
    base_nxt      = base_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    len_rd_en     = 1'b0;
    len_rd_addr   = in_slot;
    len_wr_en     = 1'b0;
    len_wr_data   = '0;
    ent_rd_en     = 1'b0;
    ent_rd_addr   = base_r;
    ent_wr_en     = 1'b0;
    ent_wr_addr   = base_r;
    ent_wr_data   = desc_r;

    // result leaves the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt  = in_data.req_type;
          desc_nxt = in_data.desc_num;
          slot_nxt = in_slot;
          base_nxt = AW'(32'(in_slot) * LIST_DEPTH);
          if (pid_bad) begin
            status_nxt = ST_ABSENT;
            cnt_nxt    = '0;
            state_nxt  = S_DONE;
          end else begin
            len_rd_en = 1'b1;
            state_nxt = S_LEN;
          end
        end
      end
      S_LEN: begin
        len_nxt    = len_q;
        cnt_nxt    = len_q;
        status_nxt = ST_OK;
        case (req_r)
          REQ_ADD: begin
            if (len_q == LW'(LIST_DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ent_wr_en   = 1'b1;
              ent_wr_addr = base_r + AW'(len_q);
              ent_wr_data = desc_r;
              len_wr_en   = 1'b1;
              len_wr_data = len_q + LW'(1);
              cnt_nxt     = len_q + LW'(1);
            end
            state_nxt = S_DONE;
          end
          REQ_CLEAR: begin
            len_wr_en   = 1'b1;
            len_wr_data = '0;
            cnt_nxt     = '0;
            state_nxt   = S_DONE;
          end
          default: begin
            if (len_q == '0) begin
              status_nxt = ST_ABSENT;
              state_nxt  = S_DONE;
            end else begin
              ent_rd_en   = 1'b1;
              ent_rd_addr = base_r;
              idx_nxt     = '0;
              state_nxt   = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (ent_q == desc_r) begin
          status_nxt = ST_OK;
          if (req_r == REQ_QUERY) begin
            state_nxt = S_DONE;
          end else begin
            cnt_nxt = len_r - LW'(1);
            if (idx_p1 < len_ext) begin
              // later entries to move down by one
              ent_rd_en   = 1'b1;
              ent_rd_addr = base_r + AW'(idx_p1);
              state_nxt   = S_SHIFT;
            end else begin
              len_wr_en   = 1'b1;
              len_wr_data = len_r - LW'(1);
              state_nxt   = S_DONE;
            end
          end
        end else if (idx_p1 == len_ext) begin
          status_nxt = ST_ABSENT;
          state_nxt  = S_DONE;
        end else begin
          ent_rd_en   = 1'b1;
          ent_rd_addr = base_r + AW'(idx_p1);
          idx_nxt     = LW'(idx_p1);
        end
      end
      S_SHIFT: begin
        // entry idx takes the value of entry idx + 1
        ent_wr_en   = 1'b1;
        ent_wr_addr = base_r + AW'(idx_r);
        ent_wr_data = ent_q;
        if (idx_p2 < len_ext) begin
          ent_rd_en   = 1'b1;
          ent_rd_addr = base_r + AW'(idx_p2);
          idx_nxt     = LW'(idx_p1);
        end else begin
          len_wr_en   = 1'b1;
          len_wr_data = len_r - LW'(1);
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = status_r;
          out_data_nxt.open_count = 5'(cnt_r);
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    slot_r     <= slot_nxt;
    desc_r     <= desc_nxt;
    base_r     <= base_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
